FILE: design/refcounted_mask_table_defines.svh
// Assertion macros used by the mask table core.
`ifndef REFCOUNTED_MASK_TABLE_DEFINES_SVH
`define REFCOUNTED_MASK_TABLE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RMT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define RMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/rmt_pkg.sv
// Types and codes shared by the mask table modules.
package rmt_pkg;

  localparam int MASK_W  = 32;
  localparam int SLOT_W  = 5;
  localparam int USERS_W = 16;

  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [MASK_W-1:0] mask_value;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  result_slot;
    status_t            status;
    logic               new_slot;
    logic [USERS_W-1:0] users_now;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic take;
  } ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } sts_t;

endpackage

FILE: design/rmt_chan_if.sv
// Valid/ready channel carrying one request or result.
interface rmt_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/refcounted_mask_table.sv
// Top level of the reference-counted mask table with its result register.
// Insert: scans the slots in order, ending at the first match, else at the last slot.
// Release: read-modify-write of the slot, none for a slot index beyond the table;
// one request in flight at a time; next request accepted the cycle after the result loads.
// Synchronous reset clears control state and per-slot valid bits; unwritten slots read
// as zero word and zero count, so no clearing pass follows reset.
module refcounted_mask_table #(
  parameter int SLOTS      = 32,
  parameter int COUNT_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  rmt_chan_if.sink    req,
  rmt_chan_if.source  rsp
);
  import rmt_pkg::*;

  ctl_t ctl;
  sts_t sts;
  rsp_t core_rsp;

  assign req.ready = sts.idle;
  assign ctl.start = req.valid && req.ready;
  assign ctl.take  = sts.done && (!rsp.valid || rsp.ready);

  rmt_core #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (req.data),
    .sts (sts),
    .rsp (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ctl.take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      rsp.data <= core_rsp;
    end
  end

endmodule

FILE: design/rmt_core.sv
// Slot memory with the insert scan and release read-modify-write sequencer.
`include "refcounted_mask_table_defines.svh"

module rmt_core #(
  parameter int SLOTS      = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  rmt_pkg::ctl_t ctl,
  input  rmt_pkg::req_t req,
  output rmt_pkg::sts_t sts,
  output rmt_pkg::rsp_t rsp
);
  import rmt_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_REL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic [MASK_W-1:0]     mask;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  entry_t mem [SLOTS];
  logic [SLOTS-1:0] vld;
  entry_t rd_data;
  logic   rd_vld;
  entry_t rd_entry;

  state_t state, state_next;
  logic [MASK_W-1:0] word;
  logic [SLOT_W-1:0] idx;
  logic [AW-1:0] iss, ev, free_slot;
  logic iss_done, pend, have_free;
  rsp_t res, res_next;

  logic we;
  logic [AW-1:0] wa, ra, fill_slot;
  entry_t wd;
  logic hit, zero, sat, last_ev, fill_ok, in_range;
  logic [COUNT_BITS-1:0] inc, dec;

  assign rd_entry  = rd_vld ? rd_data : '0;
  assign hit       = rd_entry.mask == word;
  assign zero      = rd_entry.cnt == '0;
  assign sat       = rd_entry.cnt == CMAX;
  assign inc       = sat ? CMAX : rd_entry.cnt + 1'b1;
  assign dec       = rd_entry.cnt - 1'b1;
  assign last_ev   = ev == LAST;
  assign fill_ok   = have_free || zero;
  assign fill_slot = have_free ? free_slot : ev;
  assign in_range  = 32'(req.slot_index) < 32'(SLOTS);
  assign ra        = (state == S_SCAN) ? iss : AW'(req.slot_index);

  always_comb begin
    we         = 1'b0;
    wa         = ev;
    wd         = rd_entry;
    res_next   = res;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ctl.start) begin
          if (req.func == FUNC_INSERT) begin
            state_next = S_SCAN;
          end else if (in_range) begin
            state_next = S_REL;
          end else begin
            state_next           = S_DONE;
            res_next.result_slot = req.slot_index;
            res_next.status      = ST_UNUSED;
            res_next.new_slot    = 1'b0;
            res_next.users_now   = '0;
          end
        end
      end
      S_SCAN: begin
        if (pend) begin
          if (hit) begin
            state_next           = S_DONE;
            we                   = 1'b1;
            wd.cnt               = inc;
            res_next.result_slot = SLOT_W'(ev);
            res_next.status      = sat ? ST_SAT : ST_OK;
            res_next.new_slot    = 1'b0;
            res_next.users_now   = USERS_W'(inc);
          end else if (last_ev) begin
            state_next = S_DONE;
            if (fill_ok) begin
              we                   = 1'b1;
              wa                   = fill_slot;
              wd.mask              = word;
              wd.cnt               = COUNT_BITS'(1);
              res_next.result_slot = SLOT_W'(fill_slot);
              res_next.status      = ST_OK;
              res_next.new_slot    = 1'b1;
              res_next.users_now   = USERS_W'(1);
            end else begin
              res_next.result_slot = '0;
              res_next.status      = ST_FULL;
              res_next.new_slot    = 1'b0;
              res_next.users_now   = '0;
            end
          end
        end
      end
      S_REL: begin
        state_next           = S_DONE;
        res_next.result_slot = idx;
        res_next.new_slot    = 1'b0;
        if (zero) begin
          res_next.status    = ST_UNUSED;
          res_next.users_now = '0;
        end else begin
          we                 = 1'b1;
          wa                 = AW'(idx);
          wd.cnt             = dec;
          res_next.status    = ST_OK;
          res_next.users_now = USERS_W'(dec);
        end
      end
      S_DONE: begin
        if (ctl.take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[wa] <= 1'b1;
      end
      rd_vld <= vld[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iss       <= '0;
      ev        <= '0;
      iss_done  <= 1'b0;
      pend      <= 1'b0;
      have_free <= 1'b0;
      free_slot <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && ctl.start) begin
        iss       <= '0;
        iss_done  <= 1'b0;
        pend      <= 1'b0;
        have_free <= 1'b0;
      end else if (state == S_SCAN) begin
        if (!iss_done) begin
          ev   <= iss;
          pend <= 1'b1;
          if (iss == LAST) begin
            iss_done <= 1'b1;
          end else begin
            iss <= iss + 1'b1;
          end
        end else begin
          pend <= 1'b0;
        end
        if (pend && !hit && zero && !have_free) begin
          have_free <= 1'b1;
          free_slot <= ev;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (state == S_IDLE && ctl.start) begin
      word <= req.mask_value;
      idx  <= req.slot_index;
    end
  end

  assign sts.idle = state == S_IDLE;
  assign sts.done = state == S_DONE;
  assign rsp      = res;

  `RMT_ASSERT_IMPL(a_wr_state, we, (state == S_SCAN) || (state == S_REL), "write outside evaluation")
  `RMT_ASSERT_IMPL(a_start_idle, ctl.start, state == S_IDLE, "request started while busy")
  `RMT_ASSERT_NEXT(a_take_idle, (state == S_DONE) && ctl.take, state == S_IDLE, "no return to idle")
  `RMT_ASSERT_IMPL(a_ins_cnt, we && (state == S_SCAN), wd.cnt != '0, "insert wrote zero count")

endmodule
